### rtl/gsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants for the scalar ALU
// Operation codes, transaction payload structs and bitfield-extract fields.
// ----------------------------------------------------------------------------
package gsa_pkg;

  // Operation select
  typedef enum logic [3:0] {
    ModeMov32       = 4'd0,
    ModeMov64       = 4'd1,
    ModeMovk        = 4'd2,
    ModeAdd         = 4'd3,
    ModeMul         = 4'd4,
    ModeCmpEq       = 4'd5,
    ModeCsel32      = 4'd6,
    ModeCsel64      = 4'd7,
    ModeAnd32       = 4'd8,
    ModeAnd64       = 4'd9,
    ModeAndn2       = 4'd10,
    ModeOr          = 4'd11,
    ModeNor         = 4'd12,
    ModeLshr        = 4'd13,
    ModeBfe         = 4'd14,
    ModeAndSaveExec = 4'd15
  } gsa_mode_e;

  // Shift amount / extract offset field of the second operand
  localparam int unsigned ShiftBits   = 5;
  // Extract width field of the second operand
  localparam int unsigned BfeWidthLsb = 16;
  localparam int unsigned BfeWidthBits = 7;

  // Input transaction
  typedef struct packed {
    gsa_mode_e          mode;
    logic [63:0]        first_operand;
    logic [63:0]        second_operand;
    logic signed [15:0] immediate;
  } gsa_in_t;

  // Result transaction
  typedef struct packed {
    logic [63:0] result_value;
    logic        write_enable;
    logic        flag_out;
    logic [63:0] lane_mask_out;
  } gsa_out_t;

endpackage

### rtl/gpu_scalar_alu_with_flags_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_scalar_alu_with_flags_core: scalar ALU with condition flag and exec mask
// Input register, single-pass execute, result register; flag and lane mask
// are updated as each instruction moves into the result register.
//
//   channel | signals                         | payload
//   --------+---------------------------------+-----------
//   input   | in_valid_i  / in_ready_o        | gsa_in_t
//   output  | out_valid_o / out_ready_i       | gsa_out_t
//
// An input transaction is held in the input register, executed, and its result is
// captured in the result register before the result transaction is presented.
// Throughput is one instruction per cycle while the output does not stall; the flag/mask feedback through
// the ALU is a single combinational step.
// Reset clears both stages, the flag to 0 and the lane mask to all ones.
// An output stall holds the result register and backs up into the input
// register; input stays ready while either stage can drain.
// ----------------------------------------------------------------------------
module gpu_scalar_alu_with_flags_core import gsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gsa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gsa_out_t out_data_o
);

  logic        s1_valid_q;
  gsa_in_t     s1_q;
  logic        out_valid_q;
  gsa_out_t    out_q;
  logic        flag_q;
  logic        flag_d;
  logic [63:0] mask_q;
  logic [63:0] mask_d;
  gsa_out_t    alu_res;
  logic        exec_fire;
  logic        in_fire;

  // Handshake control
  assign exec_fire  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || exec_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
  end

  // Execute
  gsa_alu u_alu (
    .item_i (s1_q),
    .flag_i (flag_q),
    .mask_i (mask_q),
    .res_o  (alu_res)
  );

  // Architectural state, committed with the transaction
  assign flag_d = exec_fire ? alu_res.flag_out : flag_q;
  assign mask_d = exec_fire ? alu_res.lane_mask_out : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      mask_q <= '1;
    end else begin
      flag_q <= flag_d;
      mask_q <= mask_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= alu_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  a_mask_only_saveexec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(exec_fire && (s1_q.mode == ModeAndSaveExec)) |=> $stable(mask_q))
    else $error("lane mask changed without and-saveexec");

  a_out_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.lane_mask_out == mask_q) && (out_q.flag_out == flag_q))
    else $error("held result disagrees with committed flag/mask");

  a_cmp_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && (s1_q.mode == ModeCmpEq)) |=> !out_q.write_enable)
    else $error("compare produced a register write");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

### rtl/gsa_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_alu: scalar ALU datapath
// Single-pass combinational execute of one instruction against the current
// condition flag and lane mask; produces the result and the next state.
// ----------------------------------------------------------------------------
module gsa_alu import gsa_pkg::*; (
  input  gsa_in_t     item_i,
  input  logic        flag_i,
  input  logic [63:0] mask_i,
  output gsa_out_t    res_o
);

  logic [63:0] a;
  logic [63:0] b;
  logic [31:0] a32;
  logic [31:0] b32;
  logic [31:0] sum32;
  logic [31:0] prod32;
  logic [31:0] shr32;
  logic [ShiftBits-1:0]    sh_amt;
  logic [BfeWidthBits-1:0] bfe_width;
  logic [31:0] bfe_mask;
  logic [31:0] bfe32;
  logic [63:0] res;
  logic        we;
  logic        set_nz;
  logic        flag_nxt;
  logic [63:0] mask_nxt;

  assign a   = item_i.first_operand;
  assign b   = item_i.second_operand;
  assign a32 = a[31:0];
  assign b32 = b[31:0];

  // Arithmetic units
  assign sum32  = a32 + b32;
  assign prod32 = a32 * b32;

  // Shifter, shared by lshr and extract (same offset field)
  assign sh_amt = b[ShiftBits-1:0];
  assign shr32  = a32 >> sh_amt;

  // Extract: bits above 31 are already zero after the shift, so clipping
  // the width at bit 31 falls out; zero width gives an empty mask
  assign bfe_width = b[BfeWidthLsb +: BfeWidthBits];
  always_comb begin
    if (bfe_width >= BfeWidthBits'(32)) begin
      bfe_mask = '1;
    end else begin
      bfe_mask = ~({32{1'b1}} << bfe_width[4:0]);
    end
  end
  assign bfe32 = shr32 & bfe_mask;

  // Operation select
  always_comb begin
    res      = '0;
    we       = 1'b1;
    set_nz   = 1'b0;
    flag_nxt = flag_i;
    mask_nxt = mask_i;
    case (item_i.mode)
      ModeMov32:  res = {32'b0, a32};
      ModeMov64:  res = a;
      ModeMovk:   res = {32'b0, {16{item_i.immediate[15]}}, item_i.immediate};
      ModeAdd:    res = {32'b0, sum32};
      ModeMul:    res = {32'b0, prod32};
      ModeCmpEq: begin
        we       = 1'b0;
        flag_nxt = (a32 == b32);
      end
      ModeCsel32: res = flag_i ? {32'b0, a32} : {32'b0, b32};
      ModeCsel64: res = flag_i ? a : b;
      ModeAnd32: begin
        res    = {32'b0, a32 & b32};
        set_nz = 1'b1;
      end
      ModeAnd64: begin
        res    = a & b;
        set_nz = 1'b1;
      end
      ModeAndn2: begin
        res    = a & ~b;
        set_nz = 1'b1;
      end
      ModeOr: begin
        res    = a | b;
        set_nz = 1'b1;
      end
      ModeNor: begin
        res    = ~(a | b);
        set_nz = 1'b1;
      end
      ModeLshr: begin
        res    = {32'b0, shr32};
        set_nz = 1'b1;
      end
      ModeBfe: begin
        res    = {32'b0, bfe32};
        set_nz = 1'b1;
      end
      ModeAndSaveExec: begin
        res      = mask_i;
        mask_nxt = a & mask_i;
        flag_nxt = |(a & mask_i);
      end
      default: begin
        res = '0;
      end
    endcase
    if (set_nz) begin
      flag_nxt = |res;
    end
  end

  assign res_o.result_value  = res;
  assign res_o.write_enable  = we;
  assign res_o.flag_out      = flag_nxt;
  assign res_o.lane_mask_out = mask_nxt;

endmodule
